// ===== hdl/qte_pkg.sv =====
package qte_pkg;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } in_t;

  typedef struct packed {
    logic signed [14:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;
  } out_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PROD = 6'b000010,
    S_SQ   = 6'b000100,
    S_ROOT = 6'b001000,
    S_CORD = 6'b010000,
    S_CONV = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    ANG_PITCH = 2'd0,
    ANG_ROLL  = 2'd1,
    ANG_YAW   = 2'd2
  } ang_t;

  localparam int                 ProdCount = 10;
  localparam logic signed [39:0] OneQ30    = 40'sd1073741824;
  localparam logic signed [36:0] SMax      = 37'sd1073741824;
  localparam logic signed [36:0] SMin      = -37'sd1073741824;
  localparam logic [60:0]        OneQ60    = 61'h1000_0000_0000_0000;
  localparam logic [55:0]        HalfTen   = 56'd5368709120;
  localparam logic signed [33:0] RecipTen  = 34'sh0_CCCC_CCCD;
  localparam logic [22:0]        LimPitch  = 23'd16383;
  localparam logic [22:0]        LimWide   = 23'd32767;

  // round(atan(2^-i) * 2^30)
  function automatic logic [29:0] qte_atan(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/qte_isqrt.sv =====
module qte_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        sq_start,
  input  logic [60:0] sq_val,
  output logic        sq_done,
  output logic [30:0] sq_root
);

  logic        busy_r;
  logic        done_r;
  logic [60:0] v_r;
  logic [61:0] res_r;
  logic [61:0] bit_r;
  logic [61:0] trial;

  assign trial   = res_r + bit_r;
  assign sq_done = done_r;
  assign sq_root = res_r[30:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (sq_start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // one result bit per cycle
  always_ff @(posedge clk) begin
    if (sq_start) begin
      v_r   <= sq_val;
      res_r <= '0;
      bit_r <= 62'd1 << 60;
    end else if (busy_r) begin
      if ({1'b0, v_r} >= trial) begin
        v_r   <= 61'({1'b0, v_r} - trial);
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

// ===== hdl/quaternion_to_euler_angles_top.sv =====
// channel  | ports                  | transaction
// ---------+------------------------+--------------------------------------
// input    | start, busy, in_data   | start high while busy low
// result   | out_valid, out_data    | out_valid high for one cycle
//
// one quaternion holds busy through the products, s^2, the square root and the three
// angles in turn; an angle with both operands zero skips its iterations. these phases
// run on the shared multiplier, the bit-serial square root and the CORDIC loop.
// busy is high from the accepting edge until the result strobe.
// synchronous reset returns the sequencer to idle; the receiver cannot stall.
module quaternion_to_euler_angles_top #(
  parameter int CORDIC_STEPS        = 24,
  parameter int ANGLE_FRACTION_BITS = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  qte_pkg::in_t  in_data,
  output logic          out_valid,
  output qte_pkg::out_t out_data
);

  import qte_pkg::*;

  localparam int                 NStep = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
  localparam logic signed [33:0] KConv = 34'(573 * (2 ** ANGLE_FRACTION_BITS));

  state_t             state_r;
  logic [5:0]         cnt_r;
  ang_t               ang_r;
  in_t                q_r;
  logic signed [67:0] prod_r;
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [35:0] acc_s_r, acc_rn_r, acc_rsq_r, acc_yn_r, acc_yd_r;
  logic signed [35:0] ps;
  logic [3:0]         pidx;
  logic signed [36:0] s2;
  logic signed [31:0] s_nxt;
  logic signed [31:0] s_r;
  logic               clamp_nxt;
  logic               clamp_r;
  logic [30:0]        c_r;
  logic               sq_done;
  logic [30:0]        sq_root;
  logic signed [39:0] ld_x, ld_y;
  logic signed [39:0] cx_r, cy_r;
  logic signed [33:0] cz_r;
  logic [4:0]         it;
  logic signed [39:0] dx, dy;
  logic signed [33:0] at;
  logic [32:0]        mag;
  logic [55:0]        nsum;
  logic [25:0]        n_val;
  logic [22:0]        q_val, q_sat;
  logic signed [15:0] ang_res;
  logic signed [14:0] pitch_r;
  logic signed [15:0] roll_r;
  logic               out_valid_r;
  out_t               out_data_r;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  qte_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .sq_start (state_r == S_ROOT && cnt_r == 6'd0),
    .sq_val   (OneQ60 - prod_r[60:0]),
    .sq_done  (sq_done),
    .sq_root  (sq_root)
  );

  // operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_PROD: begin
        case (cnt_r[3:0])
          4'd0: begin mul_a = 34'(q_r.quat_w); mul_b = 34'(q_r.quat_y); end
          4'd1: begin mul_a = 34'(q_r.quat_x); mul_b = 34'(q_r.quat_z); end
          4'd2: begin mul_a = 34'(q_r.quat_y); mul_b = 34'(q_r.quat_z); end
          4'd3: begin mul_a = 34'(q_r.quat_w); mul_b = 34'(q_r.quat_x); end
          4'd4: begin mul_a = 34'(q_r.quat_x); mul_b = 34'(q_r.quat_x); end
          4'd5: begin mul_a = 34'(q_r.quat_y); mul_b = 34'(q_r.quat_y); end
          4'd6: begin mul_a = 34'(q_r.quat_x); mul_b = 34'(q_r.quat_y); end
          4'd7: begin mul_a = 34'(q_r.quat_w); mul_b = 34'(q_r.quat_z); end
          4'd8: begin mul_a = 34'(q_r.quat_w); mul_b = 34'(q_r.quat_w); end
          4'd9: begin mul_a = 34'(q_r.quat_z); mul_b = 34'(q_r.quat_z); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_SQ: begin
        mul_a = 34'(s_nxt);
        mul_b = 34'(s_nxt);
      end
      S_CONV: begin
        if (cnt_r == 6'd0) begin
          mul_a = signed'({1'b0, mag});
          mul_b = KConv;
        end else begin
          mul_a = signed'({8'd0, n_val});
          mul_b = RecipTen;
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign ps   = 36'(prod_r >>> 30);
  assign pidx = 4'(cnt_r[3:0] - 4'd1);

  // asin argument clamp
  always_comb begin
    s2        = {acc_s_r, 1'b0};
    clamp_nxt = 1'b0;
    s_nxt     = 32'(s2);
    if (s2 > SMax) begin
      s_nxt     = 32'(SMax);
      clamp_nxt = 1'b1;
    end else if (s2 < SMin) begin
      s_nxt     = 32'(SMin);
      clamp_nxt = 1'b1;
    end
  end

  always_comb begin
    unique case (ang_r)
      ANG_PITCH: begin
        ld_y = 40'(s_r);
        ld_x = signed'({9'd0, c_r});
      end
      ANG_ROLL: begin
        ld_y = 40'(signed'({acc_rn_r, 1'b0}));
        ld_x = OneQ30 - 40'({acc_rsq_r, 1'b0});
      end
      default: begin
        ld_y = 40'(signed'({acc_yn_r, 1'b0}));
        ld_x = 40'(acc_yd_r);
      end
    endcase
  end

  assign it = 5'(cnt_r - 6'd1);
  assign dx = cy_r >>> it;
  assign dy = cx_r >>> it;
  assign at = signed'({4'd0, qte_atan(it)});

  assign mag     = cz_r[33] ? 33'(-cz_r) : 33'(cz_r);
  assign nsum    = prod_r[55:0] + HalfTen;
  assign n_val   = nsum[55:30];
  assign q_val   = prod_r[57:35];
  assign q_sat   = (ang_r == ANG_PITCH) ? ((q_val > LimPitch) ? LimPitch : q_val)
                                        : ((q_val > LimWide) ? LimWide : q_val);
  assign ang_res = cz_r[33] ? -signed'(16'(q_sat)) : signed'(16'(q_sat));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ang_r       <= ANG_PITCH;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_PROD;
            cnt_r   <= '0;
          end
        end
        S_PROD: begin
          if (cnt_r == 6'(ProdCount)) begin
            state_r <= S_SQ;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_SQ: begin
          state_r <= S_ROOT;
          cnt_r   <= '0;
        end
        S_ROOT: begin
          cnt_r <= 6'd1;
          if (sq_done) begin
            state_r <= S_CORD;
            cnt_r   <= '0;
            ang_r   <= ANG_PITCH;
          end
        end
        S_CORD: begin
          if (cnt_r == 6'd0 && ld_x == 40'sd0 && ld_y == 40'sd0) begin
            state_r <= S_CONV;
          end else if (cnt_r == 6'(NStep)) begin
            state_r <= S_CONV;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_CONV: begin
          if (cnt_r == 6'd2) begin
            cnt_r <= '0;
            unique case (ang_r)
              ANG_PITCH: begin
                ang_r   <= ANG_ROLL;
                state_r <= S_CORD;
              end
              ANG_ROLL: begin
                ang_r   <= ANG_YAW;
                state_r <= S_CORD;
              end
              default: begin
                state_r     <= S_IDLE;
                out_valid_r <= 1'b1;
              end
            endcase
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (state_r == S_IDLE && start) begin
      q_r       <= in_data;
      acc_s_r   <= '0;
      acc_rn_r  <= '0;
      acc_rsq_r <= '0;
      acc_yn_r  <= '0;
      acc_yd_r  <= '0;
    end
    if (state_r == S_PROD && cnt_r != 6'd0) begin
      case (pidx)
        4'd0: acc_s_r  <= acc_s_r + ps;
        4'd1: acc_s_r  <= acc_s_r - ps;
        4'd2, 4'd3: acc_rn_r <= acc_rn_r + ps;
        4'd4: begin
          acc_rsq_r <= acc_rsq_r + ps;
          acc_yd_r  <= acc_yd_r + ps;
        end
        4'd5: begin
          acc_rsq_r <= acc_rsq_r + ps;
          acc_yd_r  <= acc_yd_r - ps;
        end
        4'd6, 4'd7: acc_yn_r <= acc_yn_r + ps;
        4'd8: acc_yd_r <= acc_yd_r + ps;
        4'd9: acc_yd_r <= acc_yd_r - ps;
        default: acc_yd_r <= acc_yd_r;
      endcase
    end
    if (state_r == S_SQ) begin
      s_r     <= s_nxt;
      clamp_r <= clamp_nxt;
    end
    if (state_r == S_ROOT && sq_done) begin
      c_r <= sq_root;
    end
    if (state_r == S_CORD) begin
      if (cnt_r == 6'd0) begin
        cz_r <= '0;
        cx_r <= ld_x;
        cy_r <= ld_y;
        if (ld_x < 40'sd0) begin
          if (ld_y >= 40'sd0) begin
            cx_r <= ld_y;
            cy_r <= -ld_x;
            cz_r <= signed'({3'd0, qte_atan(5'd0), 1'b0});
          end else begin
            cx_r <= -ld_y;
            cy_r <= ld_x;
            cz_r <= -signed'({3'd0, qte_atan(5'd0), 1'b0});
          end
        end
      end else if (cy_r >= 40'sd0) begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        cz_r <= cz_r + at;
      end else begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        cz_r <= cz_r - at;
      end
    end
    if (state_r == S_CONV && cnt_r == 6'd2) begin
      unique case (ang_r)
        ANG_PITCH: pitch_r <= 15'(ang_res);
        ANG_ROLL:  roll_r  <= ang_res;
        default: begin
          out_data_r.pitch_angle   <= pitch_r;
          out_data_r.roll_angle    <= roll_r;
          out_data_r.yaw_angle     <= ang_res;
          out_data_r.pitch_clamped <= clamp_r;
        end
      endcase
    end
  end

endmodule
